// ===== hw/rtl/tcw_pkg.sv =====
// shared constants, command and status types for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // screen geometry and character handling
    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int TAB_STEP       = 4;
    localparam int PROTECTED_ROWS = 2;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

    // fixed field widths on the ports
    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;
    localparam int CHAR_W      = 8;
    localparam int CELL_W      = 16;

    // internal widths
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int CUR_ADDR_W = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS + 1);

    // character codes
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'h0A;

    // opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // cursor operations
    localparam logic [2:0] CUR_NONE    = 3'd0;
    localparam logic [2:0] CUR_NEWLINE = 3'd1;
    localparam logic [2:0] CUR_TAB     = 3'd2;
    localparam logic [2:0] CUR_PUT     = 3'd3;
    localparam logic [2:0] CUR_BS      = 3'd4;

    typedef struct packed {
        logic       load_item;
        logic       clear_wr;
        logic       cnt_clear;
        logic       copy_step;
        logic       blank_step;
        logic [2:0] cursor_op;
        logic       out_load;
        logic       out_from_ram;
    } tcw_cmd_t;

    typedef struct packed {
        logic is_read;
        logic ch_newline;
        logic ch_tab;
        logic ch_bs;
        logic col_zero;
        logic col_at_end;
        logic row_last;
        logic row_unprotected;
        logic tab_wraps;
        logic cnt_copy_end;
        logic cnt_last;
        logic out_free;
    } tcw_status_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// generic single write, single registered read port ram
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/tcw_controller.sv =====
// sequencing state machine for the text console writer
`timescale 1ns / 1ps

module tcw_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tcw_pkg::tcw_status_t  status,
    output tcw_pkg::tcw_cmd_t     cmd
);

    import tcw_pkg::*;

    localparam logic [3:0] S_CLEAR        = 4'd0;
    localparam logic [3:0] S_IDLE         = 4'd1;
    localparam logic [3:0] S_DISPATCH     = 4'd2;
    localparam logic [3:0] S_PUT          = 4'd3;
    localparam logic [3:0] S_POST         = 4'd4;
    localparam logic [3:0] S_SCROLL_COPY  = 4'd5;
    localparam logic [3:0] S_SCROLL_BLANK = 4'd6;
    localparam logic [3:0] S_READ_WAIT    = 4'd7;
    localparam logic [3:0] S_FINISH       = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       ret_put_reg;
    logic       ret_put_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            ret_put_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_put_reg <= ret_put_next;
        end
    end

    assign in_stall = !((state_reg == S_IDLE) && status.out_free);

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        ret_put_next = ret_put_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_read)
                begin
                    state_next = S_READ_WAIT;
                end
                else if (status.ch_newline || (status.ch_tab && status.tab_wraps))
                begin
                    cmd.cursor_op = CUR_NEWLINE;
                    if (status.row_last)
                    begin
                        cmd.cnt_clear = 1'b1;
                        ret_put_next  = 1'b0;
                        state_next    = S_SCROLL_COPY;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (status.ch_tab)
                begin
                    cmd.cursor_op = CUR_TAB;
                    state_next    = S_FINISH;
                end
                else if (status.ch_bs)
                begin
                    if (!status.col_zero || status.row_unprotected)
                    begin
                        cmd.cursor_op = CUR_BS;
                    end
                    state_next = S_FINISH;
                end
                else if (status.col_at_end)
                begin
                    // wrap first, then print on the fresh row
                    cmd.cursor_op = CUR_NEWLINE;
                    if (status.row_last)
                    begin
                        cmd.cnt_clear = 1'b1;
                        ret_put_next  = 1'b1;
                        state_next    = S_SCROLL_COPY;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.cursor_op = CUR_PUT;
                state_next    = S_POST;
            end
            S_POST:
            begin
                if (status.col_at_end)
                begin
                    cmd.cursor_op = CUR_NEWLINE;
                    if (status.row_last)
                    begin
                        cmd.cnt_clear = 1'b1;
                        ret_put_next  = 1'b0;
                        state_next    = S_SCROLL_COPY;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCROLL_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.cnt_copy_end)
                begin
                    state_next = S_SCROLL_BLANK;
                end
            end
            S_SCROLL_BLANK:
            begin
                cmd.blank_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = ret_put_reg ? S_PUT : S_FINISH;
                end
            end
            S_READ_WAIT:
            begin
                cmd.out_load     = 1'b1;
                cmd.out_from_ram = 1'b1;
                state_next       = S_IDLE;
            end
            S_FINISH:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// cursor, cell store, sweep counter and result register of the text console writer
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcw_pkg::tcw_cmd_t                   cmd,
    output tcw_pkg::tcw_status_t                status,
    input  logic                                opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0]     read_row,
    input  logic [tcw_pkg::COL_FIELD_W-1:0]     read_column,
    input  logic                                cfg_write,
    input  logic [tcw_pkg::CHAR_W-1:0]          cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tcw_pkg::CHAR_W-1:0]          cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]          cell_color,
    output logic [tcw_pkg::ROW_FIELD_W-1:0]     cursor_row,
    output logic [tcw_pkg::COL_FIELD_W-1:0]     cursor_column
);

    import tcw_pkg::*;

    // latched item
    logic                   opcode_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic [ROW_FIELD_W-1:0] rrow_reg;
    logic [COL_FIELD_W-1:0] rcol_reg;

    logic [CHAR_W-1:0]      color_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       row_next;
    logic [COL_W-1:0]       col_reg;
    logic [COL_W-1:0]       col_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic [ADDR_W-1:0]      copy_addr_reg;

    logic                   out_valid_reg;
    logic [CHAR_W-1:0]      char_out_reg;
    logic [CHAR_W-1:0]      color_out_reg;
    logic [ROW_FIELD_W-1:0] row_out_reg;
    logic [COL_FIELD_W-1:0] col_out_reg;

    logic [CUR_ADDR_W-1:0]  cur_addr;
    logic [CUR_ADDR_W-1:0]  bs_addr;
    logic [ADDR_W-1:0]      item_addr;
    logic [CNT_W-1:0]       copy_src;
    logic                   copy_active;
    logic                   range_ok;
    logic [COL_W:0]         tab_sum;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [CELL_W-1:0]      wr_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic [CELL_W-1:0]      rd_data;

    assign cur_addr    = CUR_ADDR_W'(row_reg) * CUR_ADDR_W'(COLUMNS) + CUR_ADDR_W'(col_reg);
    assign bs_addr     = cur_addr - CUR_ADDR_W'(1);
    assign item_addr   = ADDR_W'(rrow_reg) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_reg);
    assign copy_src    = cnt_reg + CNT_W'(COLUMNS);
    assign copy_active = cmd.copy_step && (cnt_reg < CNT_W'(COPY_COUNT));
    assign range_ok    = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS);
    assign tab_sum     = (COL_W + 1)'(col_reg) + (COL_W + 1)'(TAB_STEP);

    // status toward the controller
    assign status.is_read         = (opcode_reg == OP_READ);
    assign status.ch_newline      = (char_reg == CH_NEWLINE);
    assign status.ch_tab          = (char_reg == CH_TAB);
    assign status.ch_bs           = (char_reg == CH_BACKSPACE);
    assign status.col_zero        = (col_reg == '0);
    assign status.col_at_end      = (32'(col_reg) >= COLUMNS);
    assign status.row_last        = (32'(row_reg) == ROWS - 1);
    assign status.row_unprotected = (32'(row_reg) > PROTECTED_ROWS) && (row_reg != '0);
    assign status.tab_wraps       = (32'(tab_sum) >= COLUMNS);
    assign status.cnt_copy_end    = (cnt_reg == CNT_W'(COPY_COUNT));
    assign status.cnt_last        = (cnt_reg == CNT_W'(CELL_COUNT - 1));
    assign status.out_free        = !out_valid_reg || !out_stall;

    // cursor
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cursor_op)
            CUR_NEWLINE:
            begin
                col_next = '0;
                if (!status.row_last)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            CUR_TAB:
            begin
                col_next = COL_W'(tab_sum);
            end
            CUR_PUT:
            begin
                col_next = col_reg + COL_W'(1);
            end
            CUR_BS:
            begin
                if (!status.col_zero)
                begin
                    col_next = col_reg - COL_W'(1);
                end
                else
                begin
                    row_next = row_reg - ROW_W'(1);
                    col_next = COL_W'(COLUMNS);
                end
            end
            default:
            begin
                row_next = row_reg;
            end
        endcase
    end

    // sweep counter shared by the clearing pass and scrolling
    always_comb
    begin
        cnt_next  = cnt_reg;
        pend_next = copy_active;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.clear_wr || cmd.blank_step || copy_active)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // write port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[ADDR_W-1:0];
        wr_data = {COLOR_RESET, CH_BLANK};
        if (cmd.clear_wr)
        begin
            wr_en = 1'b1;
        end
        else if (pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data;
        end
        else if (cmd.blank_step)
        begin
            wr_en   = 1'b1;
            wr_data = {color_reg, CH_BLANK};
        end
        else if (cmd.cursor_op == CUR_PUT)
        begin
            wr_en   = 1'b1;
            wr_addr = cur_addr[ADDR_W-1:0];
            wr_data = {color_reg, char_reg};
        end
        else if (cmd.cursor_op == CUR_BS)
        begin
            wr_en   = 1'b1;
            wr_addr = bs_addr[ADDR_W-1:0];
            wr_data = {color_reg, CH_BLANK};
        end
    end

    assign rd_addr = copy_active ? copy_src[ADDR_W-1:0] : item_addr;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= COLOR_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                color_reg <= cfg_data;
            end
            row_reg  <= row_next;
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            opcode_reg <= opcode;
            char_reg   <= char_code;
            rrow_reg   <= read_row;
            rcol_reg   <= read_column;
        end
        copy_addr_reg <= cnt_reg[ADDR_W-1:0];
        if (cmd.out_load)
        begin
            if (cmd.out_from_ram && range_ok)
            begin
                char_out_reg  <= rd_data[CHAR_W-1:0];
                color_out_reg <= rd_data[CELL_W-1:CHAR_W];
            end
            else
            begin
                char_out_reg  <= '0;
                color_out_reg <= '0;
            end
            row_out_reg <= ROW_FIELD_W'(row_reg);
            col_out_reg <= COL_FIELD_W'(col_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign cell_char     = char_out_reg;
    assign cell_color    = color_out_reg;
    assign cursor_row    = row_out_reg;
    assign cursor_column = col_out_reg;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// top level of the text console writer: controller and datapath
`timescale 1ns / 1ps

// usage
//   input channel (in_valid / in_stall): one transaction carries opcode,
//     char_code, read_row and read_column; opcode 0 puts char_code at the
//     cursor, opcode 1 reads one cell of the 80 x 25 store
//   output channel (out_valid / out_stall): one transaction per input item
//     with cell_char, cell_color (zero for puts) and the cursor after the item
//   config channel (cfg_valid / cfg_ready / cfg_data): sets the attribute byte
//     for new characters and blanks; cfg_ready is always high
//   steps: reads pass dispatch and read-wait; newline, tab and backspace
//     pass dispatch and finish; a printable byte passes dispatch, put, post, finish
//   one item is worked at a time; a new item is not taken before the last is through
//   a scroll adds a row copy through the single ram read port plus a blank
//     fill of the last row
//   after reset the store is swept to blanks in color 0x0A, one cell per
//     cycle, while in_stall stays high
//   a stalled result stays in the output register; the next item is taken
//     in the cycle that result leaves
module text_console_writer (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::ROW_FIELD_W-1:0] read_row,
    input  logic [tcw_pkg::COL_FIELD_W-1:0] read_column,
    // config channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]      cfg_data,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tcw_pkg::CHAR_W-1:0]      cell_char,
    output logic [tcw_pkg::CHAR_W-1:0]      cell_color,
    output logic [tcw_pkg::ROW_FIELD_W-1:0] cursor_row,
    output logic [tcw_pkg::COL_FIELD_W-1:0] cursor_column
);

    import tcw_pkg::*;

    tcw_cmd_t    cmd;
    tcw_status_t status;

    // color writes are taken at any time, also during the clearing sweep
    assign cfg_ready = 1'b1;

    // state machine: sequencing of puts, reads, scrolls and the clearing sweep
    tcw_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // cursor, cell ram, sweep counter and result register
    tcw_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_column   (read_column),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cell_char     (cell_char),
        .cell_color    (cell_color),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column)
    );

endmodule
